// ===== rtl/folt_pkg.sv =====
// ----------------------------------------------------------------------------
// folt_pkg
// Shared types and codes for the frequency-ordered lookup table.
// ----------------------------------------------------------------------------
package folt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic take_prev;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic le;
  } cell_stat_t;

endpackage

// ===== rtl/folt_cell.sv =====
// ----------------------------------------------------------------------------
// folt_cell
// One table entry: key and count, loadable or shifted in from its neighbor.
// ----------------------------------------------------------------------------
module folt_cell
  import folt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [31:0]           srch_key,
  input  logic [COUNT_BITS-1:0] cmp_cnt,
  input  logic [31:0]           ld_key,
  input  logic [COUNT_BITS-1:0] ld_cnt,
  input  logic [31:0]           prev_key,
  input  logic [COUNT_BITS-1:0] prev_cnt,
  output logic [31:0]           key_r,
  output logic [COUNT_BITS-1:0] cnt_r,
  output cell_stat_t            stat
);

  assign stat.match = (key_r == srch_key);
  assign stat.le    = (cnt_r <= cmp_cnt);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= ld_key;
      cnt_r <= ld_cnt;
    end else if (ctl.take_prev) begin
      key_r <= prev_key;
      cnt_r <= prev_cnt;
    end
  end

endmodule

// ===== rtl/frequency_ordered_lookup_table.sv =====
// ----------------------------------------------------------------------------
// frequency_ordered_lookup_table
// Self-organizing table of keys kept in order of non-increasing access count.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------
//   input    | in_operation, in_key                    | start & !busy
//   result   | out_status, out_position,               | out_valid strobe
//            | out_access_count                        |
//
// In each transaction the accept cycle compares the key in every cell and
// picks the first match; the next cycle shifts the row of cells and
// registers the result, shown on out_valid in the cycle after.
// A new transaction is taken in the cycle the result is shown.
// Reset empties the table at once; no clearing pass.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module frequency_ordered_lookup_table
  import folt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_key,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_position,
  output logic [15:0] out_access_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  busy_r;
  logic                  op_r;
  logic [31:0]           key_r;
  logic [DEPTH-1:0]      hit_r;
  logic                  found_r;
  logic [COUNT_BITS-1:0] newcnt_r;
  logic [TW-1:0]         total_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [3:0]            out_position_r;
  logic [15:0]           out_access_count_r;

  logic [31:0]           cell_key [DEPTH];
  logic [COUNT_BITS-1:0] cell_cnt [DEPTH];
  cell_stat_t            stat     [DEPTH];
  cell_ctl_t             ctl      [DEPTH];

  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      first;
  logic [DEPTH:0]        seen;
  logic [DEPTH:0]        at_or_after;
  logic [DEPTH:0]        passed;

  logic                  accept;
  logic                  full;
  logic                  promote;
  logic                  append_ok;
  logic [COUNT_BITS-1:0] ld_cnt;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS-1:0] hit_cnt_inc;
  logic [IW-1:0]         load_pos;
  status_t               status_nxt;
  logic [3:0]            position_nxt;
  logic [15:0]           count_nxt;

  assign accept    = start & ~busy_r;
  assign full      = (total_r == TW'(DEPTH));
  assign promote   = busy_r & (op_r == OP_LOCATE) & found_r;
  assign append_ok = busy_r & (op_r == OP_APPEND) & ~full;
  assign ld_cnt    = (op_r == OP_LOCATE) ? newcnt_r : '0;

  assign seen[0]        = 1'b0;
  assign at_or_after[0] = 1'b0;
  assign passed[0]      = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_row
    logic ahead;

    folt_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[k]),
      .srch_key (in_key),
      .cmp_cnt  (newcnt_r),
      .ld_key   (key_r),
      .ld_cnt   (ld_cnt),
      .prev_key (cell_key[(k == 0) ? 0 : k - 1]),
      .prev_cnt (cell_cnt[(k == 0) ? 0 : k - 1]),
      .key_r    (cell_key[k]),
      .cnt_r    (cell_cnt[k]),
      .stat     (stat[k])
    );

    assign match[k]         = stat[k].match & (TW'(k) < total_r);
    assign first[k]         = match[k] & ~seen[k];
    assign seen[k+1]        = seen[k] | match[k];
    assign at_or_after[k+1] = at_or_after[k] | hit_r[k];
    assign ahead            = ~at_or_after[k+1];
    assign passed[k+1]      = ahead & stat[k].le;

    assign ctl[k].load      = (append_ok & (total_r == TW'(k)))
                            | (promote & (passed[k+1] | hit_r[k]) & ~passed[k]);
    assign ctl[k].take_prev = promote & (ahead | hit_r[k]) & passed[k];
  end

  always_comb begin
    hit_cnt  = '0;
    load_pos = '0;
    for (int k = 0; k < DEPTH; k++) begin
      hit_cnt  = hit_cnt | (first[k] ? cell_cnt[k] : '0);
      load_pos = load_pos | (ctl[k].load ? IW'(k) : '0);
    end
  end

  assign hit_cnt_inc = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + 1'b1;

  always_comb begin
    status_nxt   = ST_OK;
    position_nxt = 4'(load_pos);
    count_nxt    = 16'(ld_cnt);
    if (op_r == OP_APPEND) begin
      if (full) begin
        status_nxt   = ST_FULL;
        position_nxt = '0;
      end
      count_nxt = '0;
    end else if (!found_r) begin
      status_nxt   = ST_MISS;
      position_nxt = '0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (append_ok) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      key_r    <= in_key;
      hit_r    <= first;
      found_r  <= seen[DEPTH];
      newcnt_r <= hit_cnt_inc;
    end
    if (busy_r) begin
      out_status_r       <= status_nxt;
      out_position_r     <= position_nxt;
      out_access_count_r <= count_nxt;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_position     = out_position_r;
  assign out_access_count = out_access_count_r;

endmodule

// ===== rtl/folt_checker.sv =====
// ----------------------------------------------------------------------------
// folt_checker
// Port-level checks on transaction timing and result encoding.
// ----------------------------------------------------------------------------
module folt_checker
  import folt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_operation,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [3:0]  out_position,
  input logic [15:0] out_access_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("work cycle not followed by one result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISS ||
                   out_status == ST_FULL))
    else $error("result status out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_position == 4'd0 &&
                                         out_access_count == 16'd0)
    else $error("failed transaction reports nonzero fields");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_APPEND |=> ##1 out_access_count == 16'd0)
    else $error("append reported nonzero count");

endmodule

bind frequency_ordered_lookup_table folt_checker u_folt_checker (.*);

// ===== bench/tb_frequency_ordered_lookup_table.sv =====
// ----------------------------------------------------------------------------
// tb_frequency_ordered_lookup_table
// Self-checking bench for the frequency-ordered lookup table.
//
// Transactions are sent on the start/busy channel with random gaps. Each
// accepted transaction runs through a local model of the table: a tail
// append, or a front search that bumps the count and moves the entry forward.
// Every out_valid strobe is compared field by field with the oldest pending
// expectation. The run has two parts. A directed list covers the empty
// table, extreme keys, duplicates, misses and a full table. A random mix of
// hits, misses and appends follows.
// ----------------------------------------------------------------------------
module tb_frequency_ordered_lookup_table;
  import folt_pkg::*;

  localparam int               DEPTH      = DEPTH_DEF;
  localparam int               COUNT_BITS = COUNT_BITS_DEF;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int               RANDOM_ITEMS = 1125;
  localparam int               CYCLE_LIMIT  = 1500000;
  localparam int               REPORT_MAX   = 10;

  typedef struct packed {
    status_t     status;
    logic [3:0]  position;
    logic [15:0] access_count;
  } lookup_result_t;

  typedef struct packed {
    logic           op;
    logic [31:0]    key;
    logic           typed;
    lookup_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [31:0] in_key;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_position;
  logic [15:0] out_access_count;

  logic [31:0]           entry_key [DEPTH];
  logic [COUNT_BITS-1:0] entry_cnt [DEPTH];
  int                    entry_fill;

  lookup_result_t pending_results [$];
  stim_row_t      directed_rows [$];

  int cycle_count;
  int mismatch_count;
  int items_sent;
  int hits_seen;
  int misses_seen;
  int fulls_seen;
  int saturated_seen;

  frequency_ordered_lookup_table #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_position     (out_position),
    .out_access_count (out_access_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lookup_result_t next_lookup_result(input logic op,
                                                        input logic [31:0] key);
    lookup_result_t        r;
    int                    idx;
    int                    i;
    logic [31:0]           tk;
    logic [COUNT_BITS-1:0] tc;
    r = '0;
    r.status = ST_OK;
    idx = -1;
    if (op == OP_APPEND) begin
      if (entry_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        entry_key[entry_fill] = key;
        entry_cnt[entry_fill] = '0;
        r.position = entry_fill[3:0];
        entry_fill++;
      end
    end else begin
      for (i = 0; i < entry_fill; i++) begin
        if (idx < 0 && entry_key[i] == key) idx = i;
      end
      if (idx < 0) begin
        r.status = ST_MISS;
      end else begin
        if (entry_cnt[idx] != CNT_MAX) entry_cnt[idx]++;
        while (idx > 0 && entry_cnt[idx-1] <= entry_cnt[idx]) begin
          tk = entry_key[idx];
          tc = entry_cnt[idx];
          entry_key[idx]   = entry_key[idx-1];
          entry_cnt[idx]   = entry_cnt[idx-1];
          entry_key[idx-1] = tk;
          entry_cnt[idx-1] = tc;
          idx--;
        end
        r.position     = idx[3:0];
        r.access_count = entry_cnt[idx][15:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic op, input logic [31:0] key, input logic typed,
                         input status_t st, input logic [3:0] pos,
                         input logic [15:0] cnt);
    stim_row_t row;
    row.op  = op;
    row.key = key;
    row.typed = typed;
    row.res.status       = st;
    row.res.position     = pos;
    row.res.access_count = cnt;
    directed_rows.push_back(row);
  endtask

  task automatic issue(input logic op, input logic [31:0] key, input logic typed,
                       input lookup_result_t typed_res);
    lookup_result_t predicted;
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_lookup_result(op, key);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input lookup_result_t want,
                               input lookup_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display({"[%0t] %s: expected status=%0d position=%0d count=%0d, ",
                "got status=%0d position=%0d count=%0d"},
               $realtime, what, want.status, want.position, want.access_count,
               got.status, got.position, got.access_count);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n && out_valid) begin
      got.status       = out_status;
      got.position     = out_position;
      got.access_count = out_access_count;
      if (got.status == ST_OK && got.access_count != 0) hits_seen++;
      if (got.status == ST_MISS) misses_seen++;
      if (got.status == ST_FULL) fulls_seen++;
      if (got.access_count == 16'hFFFF) saturated_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.access_count !== want.access_count)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin
    int          n;
    int          r;
    int          burst_left;
    logic        op;
    logic [31:0] key;
    stim_row_t   row;

    cycle_count    = 0;
    mismatch_count = 0;
    items_sent     = 0;
    hits_seen      = 0;
    misses_seen    = 0;
    fulls_seen     = 0;
    saturated_seen = 0;
    entry_fill     = 0;
    burst_left     = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_operation <= OP_APPEND;
    in_key       <= '0;

    add_row(OP_LOCATE, 32'h0000_0000, 1'b1, ST_MISS, 4'd0, 16'd0);
    add_row(OP_APPEND, 32'h8000_0000, 1'b1, ST_OK,   4'd0, 16'd0);
    add_row(OP_APPEND, 32'h7FFF_FFFF, 1'b1, ST_OK,   4'd1, 16'd0);
    add_row(OP_APPEND, 32'h0000_0000, 1'b1, ST_OK,   4'd2, 16'd0);
    add_row(OP_APPEND, 32'hFFFF_FFFF, 1'b1, ST_OK,   4'd3, 16'd0);
    add_row(OP_APPEND, 32'h7FFF_FFFF, 1'b1, ST_OK,   4'd4, 16'd0);
    add_row(OP_LOCATE, 32'h7FFF_FFFF, 1'b0, ST_OK,   4'd0, 16'd0);
    add_row(OP_LOCATE, 32'h7FFF_FFFF, 1'b0, ST_OK,   4'd0, 16'd0);
    add_row(OP_LOCATE, 32'hFFFF_FFFF, 1'b0, ST_OK,   4'd0, 16'd0);
    add_row(OP_LOCATE, 32'h0000_0000, 1'b0, ST_OK,   4'd0, 16'd0);
    add_row(OP_LOCATE, 32'h5555_5555, 1'b1, ST_MISS, 4'd0, 16'd0);
    add_row(OP_LOCATE, 32'hAAAA_AAAA, 1'b1, ST_MISS, 4'd0, 16'd0);
    add_row(OP_APPEND, 32'h5555_5555, 1'b1, ST_OK,   4'd5, 16'd0);
    add_row(OP_APPEND, 32'hAAAA_AAAA, 1'b1, ST_OK,   4'd6, 16'd0);
    for (n = 7; n < DEPTH; n++)
      add_row(OP_APPEND, $urandom(), 1'b1, ST_OK, n[3:0], 16'd0);
    add_row(OP_APPEND, 32'h1234_5678, 1'b1, ST_FULL, 4'd0, 16'd0);
    add_row(OP_LOCATE, 32'h5555_5555, 1'b0, ST_OK,   4'd0, 16'd0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue(row.op, row.key, row.typed, row.res);
      hold_off(pick_gap());
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70 && entry_fill > 0) begin
        op  = OP_LOCATE;
        key = entry_key[$urandom_range(0, entry_fill - 1)];
      end else if (r < 85) begin
        op  = OP_LOCATE;
        key = $urandom();
      end else begin
        op  = OP_APPEND;
        key = $urandom();
      end
      issue(op, key, 1'b0, '0);
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 29) == 0) begin
        burst_left = $urandom_range(10, 40);
      end else begin
        hold_off(pick_gap());
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions: %0d promotions, %0d misses, %0d full appends",
             items_sent, hits_seen, misses_seen, fulls_seen);
    $display("Saturated counts seen %0d times, %0d mismatches", saturated_seen,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
